[hw/rtl/brf_pkg.sv]
// Shared constants, operation codes and field widths for the byte ring FIFO.
`default_nettype none

package brf_pkg;

    localparam int DEF_CAPACITY  = 1024;
    localparam int DEF_MAX_BURST = 64;

    localparam int FUNC_W = 3;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 11;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [FUNC_W-1:0] FN_WRITE   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_READ    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PEEK    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DISCARD = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RESET   = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_BURST = 2'b10
    } brf_state_t;

endpackage

`default_nettype wire

[hw/rtl/byte_ring_fifo_top.sv]
// Byte ring FIFO: pointer control, byte store and burst read pipeline.
//
//  Channel  | Direction | tdata (low bit up)                      | tuser      | tlast
//  s_       | in        | data_in[7:0], length[18:8], zero pad    | func[2:0]  | -
//  m_       | out       | data_out[7:0], moved[18:8], fill[29:19] | byte_valid | last
//
// Write, discard, pointer reset and empty reads each give one beat.
// A read or peek of n bytes streams n beats at one byte per cycle when m_ does not stall,
// each byte first registered in rdata_reg at the store read stage before it goes out.
// The single read port of the byte store sets that rate; no new item is taken mid-burst.
// Reset clears pointers, rd_valid and m_valid; byte_valid and the byte store are not cleared.
// A stall on m_ holds the output beat and, in a burst, backs up the store read stage.
`default_nettype none

module byte_ring_fifo_top
    import brf_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int MAX_BURST = DEF_MAX_BURST
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // data_in, length
    input  wire logic [FUNC_W-1:0]    s_tuser,   // func
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // data_out, moved, fill_level
    output logic                      m_tuser,   // byte_valid
    output logic                      m_tlast
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int PTR_W = AW + 1;
    localparam int CW    = (PTR_W > CNT_W) ? PTR_W : CNT_W;
    localparam int BW    = $clog2(MAX_BURST + 1);
    localparam int PAD_W = M_TDATA_W - BYTE_W - 2 * CNT_W;

    brf_state_t state_reg, state_next;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] pos_reg, pos_next;
    logic [BW-1:0]    rem_issue_reg, rem_issue_next;
    logic [BW-1:0]    rem_out_reg, rem_out_next;
    logic [CNT_W-1:0] burst_moved_reg, burst_moved_next;
    logic [CNT_W-1:0] burst_fill_reg, burst_fill_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [BYTE_W-1:0] rdata_reg;

    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_data_reg, m_data_next;
    logic              m_bvalid_reg, m_bvalid_next;
    logic [CNT_W-1:0]  m_moved_reg, m_moved_next;
    logic [CNT_W-1:0]  m_fill_reg, m_fill_next;
    logic              m_last_reg, m_last_next;

    logic [BYTE_W-1:0] byte_store_mem [CAPACITY];

    logic [FUNC_W-1:0] in_func;
    logic [BYTE_W-1:0] in_data;
    logic [CNT_W-1:0]  in_len;
    logic              in_accept;
    logic              out_free;
    logic [PTR_W-1:0]  fill;
    logic [CW-1:0]     fill_ext, len_ext, lim, n_rp, n_dc;
    logic              full;
    logic              wr_en;
    logic              issue;
    logic              drain;

    assign in_data = s_tdata[BYTE_W-1:0];
    assign in_len  = s_tdata[BYTE_W +: CNT_W];
    assign in_func = s_tuser;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;

    assign fill     = wp_reg - rp_reg;
    assign full     = fill[PTR_W-1];
    assign fill_ext = CW'(fill);
    assign len_ext  = CW'(in_len);
    assign lim      = (len_ext > CW'(MAX_BURST)) ? CW'(MAX_BURST) : len_ext;
    assign n_rp     = (lim > fill_ext) ? fill_ext : lim;
    assign n_dc     = (len_ext > fill_ext) ? fill_ext : len_ext;

    assign wr_en = in_accept && (in_func == FN_WRITE) && !full;
    assign drain = rd_valid_reg && out_free;
    assign issue = (state_reg == ST_BURST) && (rem_issue_reg != '0)
                   && (!rd_valid_reg || drain);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            byte_store_mem[wp_reg[AW-1:0]] <= in_data;
        end
        if (issue) begin
            rdata_reg <= byte_store_mem[pos_reg[AW-1:0]];
        end
    end

    always_comb begin
        state_next       = state_reg;
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        pos_next         = pos_reg;
        rem_issue_next   = rem_issue_reg;
        rem_out_next     = rem_out_reg;
        burst_moved_next = burst_moved_reg;
        burst_fill_next  = burst_fill_reg;
        rd_valid_next    = rd_valid_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        m_bvalid_next    = m_bvalid_reg;
        m_moved_next     = m_moved_reg;
        m_fill_next      = m_fill_reg;
        m_last_next      = m_last_reg;

        if (in_accept) begin
            m_valid_next  = 1'b1;
            m_data_next   = '0;
            m_bvalid_next = 1'b0;
            m_moved_next  = '0;
            m_fill_next   = CNT_W'(fill);
            m_last_next   = 1'b1;
            unique case (in_func)
                FN_WRITE: begin
                    if (!full) begin
                        wp_next      = wp_reg + PTR_W'(1);
                        m_moved_next = CNT_W'(1);
                        m_fill_next  = CNT_W'(fill + PTR_W'(1));
                    end
                end
                FN_READ, FN_PEEK: begin
                    if (n_rp != '0) begin
                        m_valid_next     = 1'b0;
                        state_next       = ST_BURST;
                        pos_next         = rp_reg;
                        rem_issue_next   = BW'(n_rp);
                        rem_out_next     = BW'(n_rp);
                        burst_moved_next = CNT_W'(n_rp);
                        if (in_func == FN_READ) begin
                            rp_next         = rp_reg + PTR_W'(n_rp);
                            burst_fill_next = CNT_W'(fill - PTR_W'(n_rp));
                        end else begin
                            burst_fill_next = CNT_W'(fill);
                        end
                    end
                end
                FN_DISCARD: begin
                    rp_next      = rp_reg + PTR_W'(n_dc);
                    m_moved_next = CNT_W'(n_dc);
                    m_fill_next  = CNT_W'(fill - PTR_W'(n_dc));
                end
                FN_RESET: begin
                    wp_next     = '0;
                    rp_next     = '0;
                    m_fill_next = '0;
                end
                default: begin
                end
            endcase
        end

        if (issue) begin
            pos_next       = pos_reg + PTR_W'(1);
            rem_issue_next = rem_issue_reg - BW'(1);
        end
        if (drain) begin
            m_valid_next  = 1'b1;
            m_data_next   = rdata_reg;
            m_bvalid_next = 1'b1;
            m_moved_next  = burst_moved_reg;
            m_fill_next   = burst_fill_reg;
            m_last_next   = (rem_out_reg == BW'(1));
            rem_out_next  = rem_out_reg - BW'(1);
            if (rem_out_reg == BW'(1)) begin
                state_next = ST_IDLE;
            end
        end
        if (issue) begin
            rd_valid_next = 1'b1;
        end else if (drain) begin
            rd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            rem_issue_reg <= '0;
            rem_out_reg   <= '0;
            rd_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            rem_issue_reg <= rem_issue_next;
            rem_out_reg   <= rem_out_next;
            rd_valid_reg  <= rd_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg         <= pos_next;
        burst_moved_reg <= burst_moved_next;
        burst_fill_reg  <= burst_fill_next;
        m_data_reg      <= m_data_next;
        m_bvalid_reg    <= m_bvalid_next;
        m_moved_reg     <= m_moved_next;
        m_fill_reg      <= m_fill_next;
        m_last_reg      <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_fill_reg, m_moved_reg, m_data_reg};
    assign m_tuser  = m_bvalid_reg;
    assign m_tlast  = m_last_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (wp_reg - rp_reg) <= PTR_W'(CAPACITY))
        else $error("fill level exceeds capacity");

    a_rd_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (state_reg == ST_BURST))
        else $error("store read pending outside a burst");

    a_issue_le_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BURST) |-> (rem_issue_reg <= rem_out_reg))
        else $error("more reads issued than beats delivered");

    a_no_take_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BURST) |-> !s_tready)
        else $error("input taken during a burst");

    a_burst_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_BURST) && drain && (rem_out_reg == BW'(1)))
        |=> (m_tvalid && m_tlast && (state_reg == ST_IDLE)))
        else $error("burst ended without a last beat");

endmodule

`default_nettype wire
